### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/mfglm_pkg.sv
package mfglm_pkg;

  localparam int FRAME_SAMPLES_MAX = 256;
  localparam int CNT_W = $clog2(FRAME_SAMPLES_MAX + 1);
  localparam int SUM_W = 30 + CNT_W;
  localparam int MEAN_W = 31;
  localparam int SQ_W = 32;
  localparam int SQRT_ITERS = 16;
  localparam int ITER_W = $clog2(SUM_W);
  localparam logic [SQ_W-1:0] SQ_BIT_INIT = SQ_W'(1) << (MEAN_W - 1);

  localparam int SAMPLE_W = 16;
  localparam int SAMPLE_MAX = 32767;
  localparam int GAIN_W = 8;
  localparam int GAIN_DIV = 100;
  localparam int FACTOR_W = 9;
  localparam int PROD_W = 25;
  localparam int MAG_W = 24;
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W = 25;
  localparam longint RECIP_VAL = ((64'd1 << RECIP_SHIFT) + GAIN_DIV - 1) / GAIN_DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int PM_W = MAG_W + RECIP_W;
  localparam int QA_W = PM_W - RECIP_SHIFT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_MIC_GAIN_PERCENT = '0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       frame_done;
    logic [SAMPLE_W-1:0]        frame_rms;
    logic [SAMPLE_W-1:0]        frame_peak;
  } out_item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic                     frame_end;
    logic [SUM_W-1:0]         sum;
    logic [CNT_W-1:0]         cnt;
    logic [SAMPLE_W-1:0]      peak;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } back_state_t;

endpackage

### src/mfglm_front.sv
module mfglm_front
  import mfglm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [GAIN_W-1:0]  gain,
  input  logic               in_valid,
  input  in_item_t           in_data,
  output logic               in_stall,
  input  queue_status_t      q_stat,
  output logic               push,
  output queue_entry_t       push_entry
);

  logic [SUM_W-1:0]    sum_r, sum_nxt, sum_acc;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_acc;
  logic [SAMPLE_W-1:0] peak_r, peak_nxt, peak_acc;

  logic [FACTOR_W-1:0]      factor;
  logic signed [PROD_W-1:0] prod_full;
  logic [SAMPLE_W-1:0]      mag;
  logic [2*SAMPLE_W-1:0]    sq;
  logic                     take;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    factor    = FACTOR_W'(GAIN_DIV) + FACTOR_W'(gain);
    prod_full = in_data.sample_in * $signed({1'b0, factor});
    mag       = in_data.sample_in[SAMPLE_W-1] ? SAMPLE_W'(-in_data.sample_in)
                                              : SAMPLE_W'(in_data.sample_in);
    sq        = mag * mag;
    take      = cnt_r < CNT_W'(FRAME_SAMPLES_MAX);
    sum_acc   = take ? sum_r + SUM_W'(sq) : sum_r;
    cnt_acc   = take ? cnt_r + CNT_W'(1) : cnt_r;
    peak_acc  = (take && (mag > peak_r)) ? mag : peak_r;

    push_entry.prod      = prod_full;
    push_entry.frame_end = in_data.frame_end;
    push_entry.sum       = sum_acc;
    push_entry.cnt       = cnt_acc;
    push_entry.peak      = peak_acc;

    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    peak_nxt = peak_r;
    if (push) begin
      if (in_data.frame_end) begin
        sum_nxt  = '0;
        cnt_nxt  = '0;
        peak_nxt = '0;
      end else begin
        sum_nxt  = sum_acc;
        cnt_nxt  = cnt_acc;
        peak_nxt = peak_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      peak_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      peak_r <= peak_nxt;
    end
  end

endmodule

### src/mfglm_queue.sv
module mfglm_queue
  import mfglm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  queue_entry_t  push_entry,
  input  logic          pop,
  output queue_entry_t  head,
  output queue_status_t q_stat
);

  queue_entry_t      entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head         = entries_r[rd_ptr_r];
  assign q_stat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign q_stat.empty = cnt_r == '0;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### src/mfglm_back.sv
module mfglm_back
  import mfglm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  queue_entry_t  head,
  input  queue_status_t q_stat,
  output back_status_t  bk_stat,
  output logic          out_valid,
  output out_item_t     out_data,
  input  logic          out_stall
);

  back_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [SUM_W-1:0]    div_q_r, div_q_nxt;
  logic [CNT_W-1:0]    div_rem_r, div_rem_nxt;
  logic [CNT_W-1:0]    div_d_r, div_d_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic [SQ_W-1:0]     sq_v_r, sq_v_nxt;
  logic [SQ_W-1:0]     sq_root_r, sq_root_nxt;
  logic [SQ_W-1:0]     sq_bit_r, sq_bit_nxt;
  logic [SAMPLE_W-1:0] hold_sample_r, hold_sample_nxt;
  logic [SAMPLE_W-1:0] hold_peak_r, hold_peak_nxt;

  logic                neg;
  logic [MAG_W-1:0]    amag;
  logic [PM_W-1:0]     pm;
  logic [QA_W-1:0]     qa;
  logic [SAMPLE_W-1:0] gained;

  logic [CNT_W:0]      rem_sh;
  logic                div_ge;
  logic [CNT_W:0]      rem_sub;
  logic [SUM_W-1:0]    q_step;
  logic [CNT_W-1:0]    rem_step;

  logic [SQ_W-1:0]     rb;
  logic                sq_ge;

  logic slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || !out_stall;

  // gain quotient: exact /100 by reciprocal on the magnitude
  always_comb begin
    neg  = head.prod[PROD_W-1];
    amag = neg ? MAG_W'(-head.prod) : MAG_W'(head.prod);
    pm   = PM_W'(amag) * PM_W'(RECIP);
    qa   = pm[PM_W-1:RECIP_SHIFT];
    if (neg) begin
      gained = (qa > QA_W'(SAMPLE_MAX + 1)) ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                            : SAMPLE_W'(QA_W'(0) - qa);
    end else begin
      gained = (qa > QA_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(qa);
    end
  end

  always_comb begin
    rem_sh   = {div_rem_r, div_q_r[SUM_W-1]};
    div_ge   = rem_sh >= {1'b0, div_d_r};
    rem_sub  = rem_sh - {1'b0, div_d_r};
    rem_step = div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    q_step   = {div_q_r[SUM_W-2:0], div_ge};

    rb    = sq_root_r + sq_bit_r;
    sq_ge = sq_v_r >= rb;
  end

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    div_q_nxt       = div_q_r;
    div_rem_nxt     = div_rem_r;
    div_d_nxt       = div_d_r;
    iter_nxt        = iter_r;
    sq_v_nxt        = sq_v_r;
    sq_root_nxt     = sq_root_r;
    sq_bit_nxt      = sq_bit_r;
    hold_sample_nxt = hold_sample_r;
    hold_peak_nxt   = hold_peak_r;
    bk_stat.pop     = 1'b0;
    bk_stat.busy    = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && slot_free) begin
          bk_stat.pop = 1'b1;
          if (head.frame_end) begin
            div_q_nxt       = head.sum;
            div_rem_nxt     = '0;
            div_d_nxt       = head.cnt;
            iter_nxt        = '0;
            hold_sample_nxt = gained;
            hold_peak_nxt   = head.peak;
            state_nxt       = BK_DIV;
          end else begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.sample_out = gained;
            out_data_nxt.frame_done = 1'b0;
            out_data_nxt.frame_rms  = '0;
            out_data_nxt.frame_peak = '0;
          end
        end
      end
      BK_DIV: begin
        bk_stat.busy = 1'b1;
        div_q_nxt    = q_step;
        div_rem_nxt  = rem_step;
        iter_nxt     = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(SUM_W - 1)) begin
          sq_v_nxt    = SQ_W'(q_step[MEAN_W-1:0]);
          sq_root_nxt = '0;
          sq_bit_nxt  = SQ_BIT_INIT;
          iter_nxt    = '0;
          state_nxt   = BK_SQRT;
        end
      end
      BK_SQRT: begin
        bk_stat.busy = 1'b1;
        sq_v_nxt     = sq_ge ? sq_v_r - rb : sq_v_r;
        sq_root_nxt  = sq_ge ? (sq_root_r >> 1) + sq_bit_r : sq_root_r >> 1;
        sq_bit_nxt   = sq_bit_r >> 2;
        iter_nxt     = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(SQRT_ITERS - 1)) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.sample_out = hold_sample_r;
          out_data_nxt.frame_done = 1'b1;
          out_data_nxt.frame_rms  = sq_root_r[SAMPLE_W-1:0];
          out_data_nxt.frame_peak = hold_peak_r;
          state_nxt               = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r    <= out_data_nxt;
    div_q_r       <= div_q_nxt;
    div_rem_r     <= div_rem_nxt;
    div_d_r       <= div_d_nxt;
    iter_r        <= iter_nxt;
    sq_v_r        <= sq_v_nxt;
    sq_root_r     <= sq_root_nxt;
    sq_bit_r      <= sq_bit_nxt;
    hold_sample_r <= hold_sample_nxt;
    hold_peak_r   <= hold_peak_nxt;
  end

endmodule

### src/mic_frame_gain_and_level_meter_unit.sv
// Ordinary samples: queue, then output register; one transaction per cycle
// when not stalled. Frame-closing sample: SUM_W (39) restoring-divide steps
// + 16 root steps in the back end; the 4-entry queue keeps taking input.
// Sustained rate is set by the shared divide/root sequencer, one per frame.
// Reset (rst_n low, synchronous) clears gain, accumulators, queue, out_valid.
`include "assert_macros.svh"

module mic_frame_gain_and_level_meter_unit
  import mfglm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_item_t          in_data,
  output logic              in_stall,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              out_stall,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic              reg_hit;

  queue_status_t fq_stat;
  queue_entry_t  fq_head;
  queue_entry_t  push_entry;
  logic          push;
  back_status_t  bk_stat;

  assign pready  = 1'b1;
  assign reg_hit = paddr[ADDR_W-1:2] == REG_MIC_GAIN_PERCENT;
  assign prdata  = reg_hit ? DATA_W'(gain_r) : '0;

  always_comb begin
    gain_nxt = gain_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      gain_nxt = pwdata[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else begin
      gain_r <= gain_nxt;
    end
  end

  mfglm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .gain       (gain_r),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .q_stat     (fq_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  mfglm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (bk_stat.pop),
    .head       (fq_head),
    .q_stat     (fq_stat)
  );

  mfglm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (fq_head),
    .q_stat    (fq_stat),
    .bk_stat   (bk_stat),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  `ASSERT_IMPL(a_pop_nonempty, bk_stat.pop, !fq_stat.empty)
  `ASSERT_IMPL(a_no_pop_busy, bk_stat.busy, !bk_stat.pop)
  `ASSERT_NEXT(a_end_starts_div, bk_stat.pop && fq_head.frame_end, bk_stat.busy)
  `ASSERT_IMPL(a_rms_le_peak, out_valid && out_data.frame_done, out_data.frame_rms <= out_data.frame_peak)

endmodule
